// File: design/tlg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_pkg
// shared types, constants and the sine table of the turtle line generator
// ----------------------------------------------------------------------------
package tlg_pkg;

  // default fixed-point format of the coordinates
  localparam int FRAC_BITS_DEF      = 16;
  localparam int COORD_INT_BITS_DEF = 21;

  // sine table entries carry 16 fraction bits
  localparam int TABLE_FRAC = 16;
  localparam int TRIG_W     = 17;

  // command word widths
  localparam int MODE_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int DEG_W    = 9;

  // home register
  localparam int                HOME_W     = 20;
  localparam logic [HOME_W-1:0] HOME_RESET = 20'd250;

  // degree arithmetic
  localparam logic [DEG_W-1:0] DEG_FULL    = 9'd360;
  localparam logic [DEG_W-1:0] DEG_HALF    = 9'd180;
  localparam logic [DEG_W-1:0] DEG_QUARTER = 9'd90;

  // floor(2^24 / 360): quotient estimate is exact or one low
  localparam logic [15:0] RECIP_360   = 16'd46603;
  localparam int          RECIP_SHIFT = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_HOME     = 3'd0,
    MODE_PEN_DOWN = 3'd1,
    MODE_PEN_UP   = 3'd2,
    MODE_TURN     = 3'd3,
    MODE_MOVE     = 3'd4
  } mode_t;

  // decoded command held in the input stage
  typedef struct packed {
    mode_t               mode;
    logic                amt_neg;
    logic [AMOUNT_W-1:0] amt_mag;   // |amount|, 32768 fits
    logic [DEG_W-1:0]    turn_deg;  // amount mod 360, 0..359
  } cmd_t;

  // handshake status of the execute step
  typedef struct packed {
    logic fire;   // command in the input stage is consumed this cycle
    logic emit;   // command is a move with the pen down
  } core_stat_t;

  // sine or cosine as sign and magnitude
  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  localparam logic [TRIG_W-1:0] QUARTER_SINE [91] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // sine of a heading 0..359 from the quarter-wave table
  function automatic trig_t sine_of(input logic [DEG_W-1:0] deg);
    trig_t            res;
    logic [DEG_W-1:0] d;
    res.neg = (deg > DEG_HALF);
    d       = res.neg ? (deg - DEG_HALF) : deg;
    if (d > DEG_QUARTER) begin
      d = DEG_HALF - d;
    end
    res.mag = QUARTER_SINE[d[6:0]];
    return res;
  endfunction

  // cosine as the sine a quarter turn ahead
  function automatic trig_t cosine_of(input logic [DEG_W-1:0] deg);
    logic [DEG_W:0] s;
    logic [DEG_W-1:0] d;
    s = {1'b0, deg} + {1'b0, DEG_QUARTER};
    if (s >= {1'b0, DEG_FULL}) begin
      s = s - {1'b0, DEG_FULL};
    end
    d = s[DEG_W-1:0];
    return sine_of(d);
  endfunction

endpackage
`default_nettype wire

// File: design/turtle_line_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// turtle_line_generator_top
// turtle-graphics engine: turns, moves and pen commands in, line segments out
// ----------------------------------------------------------------------------
// a pen-down move beat is registered in the input stage, then its segment in the result register
// throughput: one command beat per cycle but for the stall below; the turtle state update is
//   one table entry times the step count, one add and clamp per axis
// a waiting segment holds back only a following pen-down move; other commands pass
// reset: synchronous active-low rst_n, home register 250, turtle at home, heading 0,
//   pen down, both stages empty
// ----------------------------------------------------------------------------
module turtle_line_generator_top #(
  parameter int FRAC_BITS      = tlg_pkg::FRAC_BITS_DEF,
  parameter int COORD_INT_BITS = tlg_pkg::COORD_INT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration: home position
  input  wire logic                                 cfg_wr_en,
  input  wire logic [tlg_pkg::HOME_W-1:0]           cfg_wr_data,
  // command beats
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [tlg_pkg::AMOUNT_W-1:0]         in_tdata,  // amount
  input  wire logic [tlg_pkg::MODE_W-1:0]           in_tuser,  // mode
  // segment beats
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // from_x, from_y, to_x, to_y, each COORD_INT_BITS wide, zero fill on top
  output logic [((4*COORD_INT_BITS+7)/8)*8-1:0]     out_tdata
);

  localparam int POS_W = COORD_INT_BITS + FRAC_BITS;

  logic                     cmd_valid;
  tlg_pkg::cmd_t            cmd;
  tlg_pkg::core_stat_t      stat;
  logic                     out_free;
  logic signed [POS_W-1:0]  old_x, old_y, new_x, new_y;

  // input register: decode and angle reduction
  tlg_cmd_stage u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // turtle state; consumes the staged command, a pen-down move only when the result side has room
  tlg_core #(
    .FRAC_BITS      (FRAC_BITS),
    .COORD_INT_BITS (COORD_INT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .out_free    (out_free),
    .stat        (stat),
    .old_x       (old_x),
    .old_y       (old_y),
    .new_x       (new_x),
    .new_y       (new_y)
  );

  // result register with integer truncation on the way out
  tlg_out_stage #(
    .FRAC_BITS      (FRAC_BITS),
    .COORD_INT_BITS (COORD_INT_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stat.fire && stat.emit),
    .old_x      (old_x),
    .old_y      (old_y),
    .new_x      (new_x),
    .new_y      (new_y),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a staged command waits only behind a full, stalled result register
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !stat.fire) |-> (stat.emit && out_tvalid && !out_tready))
    else $error("staged command stalled without a blocked segment");

  // every new segment beat comes from a consumed pen-down move
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(stat.fire && stat.emit))
    else $error("segment beat without a pen-down move");

  // a consumed pen-down move always lands in the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    (stat.fire && stat.emit) |=> out_tvalid)
    else $error("pen-down move lost its segment");

endmodule
`default_nettype wire

// File: design/tlg_cmd_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_cmd_stage
// input register: decodes a command beat and reduces the turn angle mod 360
// ----------------------------------------------------------------------------
module tlg_cmd_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tlg_pkg::AMOUNT_W-1:0]  in_tdata,
  input  wire logic [tlg_pkg::MODE_W-1:0]    in_tuser,
  input  wire tlg_pkg::core_stat_t           stat,
  output logic                               cmd_valid,
  output tlg_pkg::cmd_t                      cmd
);

  logic                             cmd_valid_r;
  tlg_pkg::cmd_t                    cmd_r;
  tlg_pkg::cmd_t                    cmd_nxt;
  logic [tlg_pkg::AMOUNT_W-1:0]     mag;
  logic [31:0]                      q_prod;
  logic [7:0]                       q_est;
  logic [16:0]                      q_times;
  logic [9:0]                       r_est;
  logic [tlg_pkg::DEG_W-1:0]        r_mod;

  assign in_tready = !cmd_valid_r || stat.fire;

  always_comb begin
    mag     = in_tdata[tlg_pkg::AMOUNT_W-1] ? (~in_tdata + 16'd1) : in_tdata;
    // quotient by reciprocal, then at most one correction
    q_prod  = 32'(mag) * 32'(tlg_pkg::RECIP_360);
    q_est   = q_prod[31:tlg_pkg::RECIP_SHIFT];
    q_times = 17'(q_est) * 17'(tlg_pkg::DEG_FULL);
    r_est   = 10'(17'(mag) - q_times);
    r_mod   = (r_est >= 10'(tlg_pkg::DEG_FULL)) ? 9'(r_est - 10'(tlg_pkg::DEG_FULL))
                                                : r_est[8:0];
    cmd_nxt.mode     = tlg_pkg::mode_t'(in_tuser);
    cmd_nxt.amt_neg  = in_tdata[tlg_pkg::AMOUNT_W-1];
    cmd_nxt.amt_mag  = mag;
    cmd_nxt.turn_deg = (cmd_nxt.amt_neg && (r_mod != '0)) ? (tlg_pkg::DEG_FULL - r_mod)
                                                           : r_mod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      cmd_valid_r <= 1'b1;
    end else if (stat.fire) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule
`default_nettype wire

// File: design/tlg_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_core
// turtle state and the combinational turn and move datapath
// ----------------------------------------------------------------------------
module tlg_core #(
  parameter int FRAC_BITS      = tlg_pkg::FRAC_BITS_DEF,
  parameter int COORD_INT_BITS = tlg_pkg::COORD_INT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tlg_pkg::HOME_W-1:0]         cfg_wr_data,
  input  wire logic                               cmd_valid,
  input  wire tlg_pkg::cmd_t                      cmd,
  input  wire logic                               out_free,
  output tlg_pkg::core_stat_t                     stat,
  output logic signed [COORD_INT_BITS+FRAC_BITS-1:0] old_x,
  output logic signed [COORD_INT_BITS+FRAC_BITS-1:0] old_y,
  output logic signed [COORD_INT_BITS+FRAC_BITS-1:0] new_x,
  output logic signed [COORD_INT_BITS+FRAC_BITS-1:0] new_y
);

  localparam int POS_W    = COORD_INT_BITS + FRAC_BITS;
  localparam int SCALE_UP = (FRAC_BITS >= tlg_pkg::TABLE_FRAC) ?
                            (FRAC_BITS - tlg_pkg::TABLE_FRAC) : 0;
  localparam int SCALE_DN = (FRAC_BITS < tlg_pkg::TABLE_FRAC) ?
                            (tlg_pkg::TABLE_FRAC - FRAC_BITS) : 0;
  localparam int PROD_W   = 34;
  localparam int DM_W     = PROD_W + SCALE_UP;
  localparam int SUM_W    = ((POS_W > DM_W + 1) ? POS_W : (DM_W + 1)) + 1;
  localparam logic [PROD_W-1:0] HALF = (PROD_W'(1) << SCALE_DN) >> 1;
  localparam logic [63:0] INT_MAX = (64'(1) << (COORD_INT_BITS - 1)) - 64'(1);
  localparam logic signed [POS_W-1:0] POS_HI = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_LO = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(POS_HI);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(POS_LO);

  logic [tlg_pkg::HOME_W-1:0]   home_r;
  logic signed [POS_W-1:0]      pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0]      pos_y_r, pos_y_nxt;
  logic [tlg_pkg::DEG_W-1:0]    heading_r, heading_nxt;
  tlg_pkg::trig_t               sin_r, sin_nxt;
  tlg_pkg::trig_t               cos_r, cos_nxt;
  logic                         pen_r, pen_nxt;

  logic [tlg_pkg::DEG_W:0]      turn_sum;
  logic [tlg_pkg::DEG_W-1:0]    turn_deg;
  logic [PROD_W-1:0]            prod_x, prod_y;
  logic [PROD_W-1:0]            rnd_x, rnd_y;
  logic [DM_W-1:0]              mag_x, mag_y;
  logic signed [SUM_W-1:0]      dx, dy, sum_x, sum_y;
  logic signed [POS_W-1:0]      move_x, move_y;
  logic signed [POS_W-1:0]      home_fix;
  logic signed [POS_W-1:0]      home_fix_rst;
  logic                         is_move;

  // home coordinate in fixed point, saturated to the coordinate range
  function automatic logic signed [POS_W-1:0] home_sat(input logic [tlg_pkg::HOME_W-1:0] h);
    logic [63:0] hw;
    hw = 64'(h);
    if (hw > INT_MAX) begin
      return POS_HI;
    end
    return POS_W'(hw << FRAC_BITS);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
    if (v > SUM_HI) begin
      return POS_HI;
    end
    if (v < SUM_LO) begin
      return POS_LO;
    end
    return v[POS_W-1:0];
  endfunction

  assign home_fix     = home_sat(home_r);
  assign home_fix_rst = home_sat(tlg_pkg::HOME_RESET);

  // handshake
  assign is_move   = (cmd.mode == tlg_pkg::MODE_MOVE);
  assign stat.emit = cmd_valid && is_move && pen_r;
  assign stat.fire = cmd_valid && (!(is_move && pen_r) || out_free);

  // move: exact product, rescale with rounding, signed add and clamp
  always_comb begin
    prod_x = PROD_W'(sin_r.mag) * PROD_W'(cmd.amt_mag);
    prod_y = PROD_W'(cos_r.mag) * PROD_W'(cmd.amt_mag);
    rnd_x  = (prod_x + HALF) >> SCALE_DN;
    rnd_y  = (prod_y + HALF) >> SCALE_DN;
    mag_x  = DM_W'(rnd_x) << SCALE_UP;
    mag_y  = DM_W'(rnd_y) << SCALE_UP;
    dx     = (sin_r.neg ^ cmd.amt_neg) ? -$signed(SUM_W'(mag_x)) : $signed(SUM_W'(mag_x));
    dy     = (cos_r.neg ^ cmd.amt_neg) ? -$signed(SUM_W'(mag_y)) : $signed(SUM_W'(mag_y));
    sum_x  = SUM_W'(pos_x_r) + dx;
    sum_y  = SUM_W'(pos_y_r) - dy;
    move_x = clamp(sum_x);
    move_y = clamp(sum_y);
  end

  // turn: add the pre-reduced angle, wrap once
  always_comb begin
    turn_sum = {1'b0, heading_r} + {1'b0, cmd.turn_deg};
    if (turn_sum >= {1'b0, tlg_pkg::DEG_FULL}) begin
      turn_sum = turn_sum - {1'b0, tlg_pkg::DEG_FULL};
    end
    turn_deg = turn_sum[tlg_pkg::DEG_W-1:0];
  end

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    heading_nxt = heading_r;
    sin_nxt     = sin_r;
    cos_nxt     = cos_r;
    pen_nxt     = pen_r;
    if (stat.fire) begin
      unique case (cmd.mode)
        tlg_pkg::MODE_HOME: begin
          pos_x_nxt   = home_fix;
          pos_y_nxt   = home_fix;
          heading_nxt = '0;
          sin_nxt     = tlg_pkg::sine_of('0);
          cos_nxt     = tlg_pkg::cosine_of('0);
          pen_nxt     = 1'b1;
        end
        tlg_pkg::MODE_PEN_DOWN: begin
          pen_nxt = 1'b1;
        end
        tlg_pkg::MODE_PEN_UP: begin
          pen_nxt = 1'b0;
        end
        tlg_pkg::MODE_TURN: begin
          heading_nxt = turn_deg;
          sin_nxt     = tlg_pkg::sine_of(turn_deg);
          cos_nxt     = tlg_pkg::cosine_of(turn_deg);
        end
        tlg_pkg::MODE_MOVE: begin
          pos_x_nxt = move_x;
          pos_y_nxt = move_y;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r    <= tlg_pkg::HOME_RESET;
      pos_x_r   <= home_fix_rst;
      pos_y_r   <= home_fix_rst;
      heading_r <= '0;
      sin_r     <= tlg_pkg::sine_of('0);
      cos_r     <= tlg_pkg::cosine_of('0);
      pen_r     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        home_r <= cfg_wr_data;
      end
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      heading_r <= heading_nxt;
      sin_r     <= sin_nxt;
      cos_r     <= cos_nxt;
      pen_r     <= pen_nxt;
    end
  end

  assign old_x = pos_x_r;
  assign old_y = pos_y_r;
  assign new_x = move_x;
  assign new_y = move_y;

endmodule
`default_nettype wire

// File: design/tlg_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlg_out_stage
// result register: holds a segment and presents its endpoints truncated to integers
// ----------------------------------------------------------------------------
module tlg_out_stage #(
  parameter int FRAC_BITS      = tlg_pkg::FRAC_BITS_DEF,
  parameter int COORD_INT_BITS = tlg_pkg::COORD_INT_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   load,
  input  wire logic signed [COORD_INT_BITS+FRAC_BITS-1:0] old_x,
  input  wire logic signed [COORD_INT_BITS+FRAC_BITS-1:0] old_y,
  input  wire logic signed [COORD_INT_BITS+FRAC_BITS-1:0] new_x,
  input  wire logic signed [COORD_INT_BITS+FRAC_BITS-1:0] new_y,
  output logic                                        out_free,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [((4*COORD_INT_BITS+7)/8)*8-1:0]       out_tdata
);

  localparam int POS_W = COORD_INT_BITS + FRAC_BITS;
  localparam int TD_W  = ((4*COORD_INT_BITS+7)/8)*8;

  logic                    valid_r;
  logic [POS_W-1:0]        pt_r [4];
  logic [COORD_INT_BITS-1:0] ip [4];

  assign out_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pt_r[0] <= old_x;
      pt_r[1] <= old_y;
      pt_r[2] <= new_x;
      pt_r[3] <= new_y;
    end
  end

  // floor, plus one for a negative value with a fraction: truncation toward zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ip[i] = pt_r[i][POS_W-1:FRAC_BITS]
            + COORD_INT_BITS'(pt_r[i][POS_W-1] && (|pt_r[i][FRAC_BITS-1:0]));
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = TD_W'({ip[3], ip[2], ip[1], ip[0]});

endmodule
`default_nettype wire
